/* hdl/lsrb_pkg.sv */
// Shared types and constants for the Laplacian stencil row builder.
// No dependencies; imported by every module of the block.
package lsrb_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int NUM_TARGETS = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_GRID_STEP   = 2'd1;
  localparam logic [1:0] REG_POS_LIMIT   = 2'd2;
  localparam logic [1:0] REG_MATCH_TOL   = 2'd3;

  localparam logic signed [3:0] ENTRY_DIAG     = -4'sd6;
  localparam logic signed [3:0] ENTRY_NEIGHBOR = 4'sd1;

  typedef struct packed {
    logic               operation;
    logic [5:0]         cell_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic [5:0]        column;
    logic signed [3:0] entry_value;
    logic              row_last;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic       valid;
    logic       tail;
    logic       diag;
    logic       hit;
    logic [5:0] column;
    point_t     pt;
  } flow_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTRE,
    S_SWEEP,
    S_DRAIN,
    S_FLUSH
  } state_e;

endpackage

/* hdl/lsrb_cell.sv */
// One target cell of the matching chain: holds one neighbor target and
// tests each passing point against it in three stages. Uses lsrb_pkg.
module lsrb_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  lsrb_pkg::point_t target_i,
  input  logic [30:0]    tol_i,
  input  logic [61:0]    tol_sq_i,
  input  lsrb_pkg::flow_t flow_i,
  output lsrb_pkg::flow_t flow_o
);
  import lsrb_pkg::*;

  point_t      target_q;
  flow_t       s1_q, s2_q, s3_q, s3_d;
  logic        s1_ok_q, s2_ok_q;
  logic [30:0] s1_d_q [3];
  logic [61:0] s2_sq_q [3];

  logic signed [32:0] diff [3];
  logic [32:0]        dabs [3];
  logic               ok_d;
  logic [63:0]        sum;
  logic               hit;

  always_comb begin
    diff[0] = {flow_i.pt.x[31], flow_i.pt.x} - {target_q.x[31], target_q.x};
    diff[1] = {flow_i.pt.y[31], flow_i.pt.y} - {target_q.y[31], target_q.y};
    diff[2] = {flow_i.pt.z[31], flow_i.pt.z} - {target_q.z[31], target_q.z};
    ok_d = 1'b1;
    for (int k = 0; k < 3; k++) begin
      dabs[k] = diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
      if (dabs[k] >= {2'b00, tol_i}) ok_d = 1'b0;
    end
  end

  assign sum = 64'(s2_sq_q[0]) + 64'(s2_sq_q[1]) + 64'(s2_sq_q[2]);
  assign hit = s2_ok_q && (sum < {2'b00, tol_sq_i});

  always_comb begin
    s3_d     = s2_q;
    s3_d.hit = s2_q.hit | hit;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) target_q <= target_i;
    for (int k = 0; k < 3; k++) begin
      s1_d_q[k]  <= dabs[k][30:0];
      s2_sq_q[k] <= s1_d_q[k] * s1_d_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      s2_q    <= '0;
      s3_q    <= '0;
      s1_ok_q <= 1'b0;
      s2_ok_q <= 1'b0;
    end else begin
      s1_q     <= flow_i;
      s1_ok_q  <= ok_d;
      s2_q     <= s1_q;
      s2_ok_q  <= s1_ok_q;
      s3_q     <= s3_d;
    end
  end

  assign flow_o = s3_q;

endmodule

/* hdl/laplacian_stencil_row_builder.sv */
// Seven-point Laplacian row builder: point store, sweep control, a chain of
// six target cells and the result stage. Uses lsrb_pkg and lsrb_cell.
// Load: busy_o stays low. Query: busy_o is high through the centre read, one
// store read per point, the cell chain plus tail check and the flush; the last
// result appears in the first cycle with busy_o low. Receiver cannot stall;
// reset returns to idle.
module laplacian_stencil_row_builder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  lsrb_pkg::in_word_t   in_i,
  output logic                 result_valid_o,
  output lsrb_pkg::out_word_t  result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lsrb_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [6:0]  pc_q;
  logic [30:0] step_q, limit_q, tol_q;
  logic [61:0] tol_sq_q;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, active;
  logic [5:0]    row_q;
  logic [95:0]   mem [MAX_POINTS];
  logic [95:0]   rd_q;
  logic [AW-1:0] rd_addr;
  flow_t         feed_q;
  flow_t         chain [NUM_TARGETS+1];
  point_t        centre;
  point_t        tgt [NUM_TARGETS];
  logic          accept, idx_ok, sweep_end;
  logic          pend_v_q, pend_v_d, out_v_d;
  out_word_t     pend_q, pend_d, out_d;
  flow_t         ex;
  logic          emit;

  assign pready = 1'b1;
  assign accept = start_i && !busy_o;
  assign idx_ok = (32'(in_i.cell_index) < MAX_POINTS);
  assign busy_o = (state_q != S_IDLE);
  assign active = (32'(pc_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(pc_q);
  assign sweep_end = (cnt_q == active - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= 7'd64;
      step_q  <= 31'd65536;
      limit_q <= 31'd655360;
      tol_q   <= 31'd66;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_POINT_COUNT: pc_q    <= pwdata[6:0];
        REG_GRID_STEP:   step_q  <= pwdata[30:0];
        REG_POS_LIMIT:   limit_q <= pwdata[30:0];
        REG_MATCH_TOL:   tol_q   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POINT_COUNT: prdata = {25'b0, pc_q};
      REG_GRID_STEP:   prdata = {1'b0, step_q};
      REG_POS_LIMIT:   prdata = {1'b0, limit_q};
      REG_MATCH_TOL:   prdata = {1'b0, tol_q};
      default:         prdata = '0;
    endcase
  end

  assign rd_addr = (state_q == S_SWEEP) ? AW'(cnt_q) : AW'(in_i.cell_index);

  always_ff @(posedge clk_i) begin
    if (accept && in_i.operation == OP_LOAD && idx_ok)
      mem[AW'(in_i.cell_index)] <= {in_i.coord_x, in_i.coord_y, in_i.coord_z};
    rd_q <= mem[rd_addr];
    if (state_q == S_CENTRE) tol_sq_q <= tol_q * tol_q;
    if (accept) row_q <= in_i.cell_index;
  end

  assign centre = rd_q;

  always_comb begin
    logic signed [33:0] m;
    logic [33:0]        mabs;
    logic signed [31:0] c;
    for (int a = 0; a < NUM_TARGETS; a++) begin
      tgt[a] = centre;
      unique case (a / 2)
        0:       c = centre.x;
        1:       c = centre.y;
        default: c = centre.z;
      endcase
      if (a % 2 == 0) m = 34'(c) - $signed({3'b0, step_q});
      else            m = 34'(c) + $signed({3'b0, step_q});
      mabs = m[33] ? 34'(-m) : 34'(m);
      if (mabs < {3'b0, limit_q}) begin
        unique case (a / 2)
          0:       tgt[a].x = m[31:0];
          1:       tgt[a].y = m[31:0];
          default: tgt[a].z = m[31:0];
        endcase
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept && in_i.operation == OP_QUERY && idx_ok) state_d = S_CENTRE;
      S_CENTRE: state_d = (active == '0) ? S_FLUSH : S_SWEEP;
      S_SWEEP:  if (sweep_end) state_d = S_DRAIN;
      S_DRAIN:  if (ex.valid && ex.tail) state_d = S_FLUSH;
      S_FLUSH:  state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    unique case (state_q)
      S_CENTRE: cnt_d = '0;
      S_SWEEP:  cnt_d = cnt_q + CW'(1);
      default:  cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      feed_q  <= '0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      feed_q.valid  <= (state_q == S_SWEEP);
      feed_q.tail   <= sweep_end;
      feed_q.diag   <= (32'(cnt_q) == 32'(row_q));
      feed_q.hit    <= 1'b0;
      feed_q.column <= 6'(cnt_q);
    end
  end

  always_comb begin
    chain[0]    = feed_q;
    chain[0].pt = rd_q;
  end

  for (genvar g = 0; g < NUM_TARGETS; g++) begin : g_cell
    lsrb_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (state_q == S_CENTRE),
      .target_i (tgt[g]),
      .tol_i    (tol_q),
      .tol_sq_i (tol_sq_q),
      .flow_i   (chain[g]),
      .flow_o   (chain[g+1])
    );
  end

  assign ex   = chain[NUM_TARGETS];
  assign emit = ex.valid && (ex.hit || ex.diag);

  always_comb begin
    out_v_d  = 1'b0;
    out_d    = pend_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    if (emit) begin
      out_v_d            = pend_v_q;
      out_d.row_last     = 1'b0;
      pend_v_d           = 1'b1;
      pend_d.column      = ex.column;
      pend_d.entry_value = ex.diag ? ENTRY_DIAG : ENTRY_NEIGHBOR;
      pend_d.row_last    = 1'b0;
    end
    if (state_q == S_FLUSH) begin
      out_v_d        = pend_v_q;
      out_d.row_last = 1'b1;
      pend_v_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q       <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      pend_v_q       <= pend_v_d;
      result_valid_o <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    result_o <= out_d;
  end

endmodule

/* hdl/lsrb_checker.sv */
// Port-level checks for the Laplacian stencil row builder, bound to the top.
// Uses lsrb_pkg.
module lsrb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input lsrb_pkg::in_word_t  in_i,
  input logic                result_valid_o,
  input lsrb_pkg::out_word_t result_o
);
  import lsrb_pkg::*;

  a_result_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result word outside a query");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.row_last |=> !result_valid_o)
    else $error("result word right after row end");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && in_i.operation == OP_LOAD |=> !busy_o)
    else $error("load raised busy");

  a_entry_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (result_o.entry_value == ENTRY_DIAG || result_o.entry_value == ENTRY_NEIGHBOR))
    else $error("bad entry value");

endmodule

bind laplacian_stencil_row_builder lsrb_checker u_lsrb_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench for laplacian_stencil_row_builder: loads points,
// queries rows and predicts every nonzero entry. Depends on lsrb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import lsrb_pkg::*;

  typedef longint vec3_t[3];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  in_word_t    in_i = '0;
  logic        result_valid_o;
  out_word_t   result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  laplacian_stencil_row_builder dut (.*);

  always #5 clk_i = ~clk_i;

  longint          pts_x[64], pts_y[64], pts_z[64];
  bit              loaded[64];
  longint unsigned cnt_cfg = 64, step_cfg = 65536, limit_cfg = 655360, tol_cfg = 66;
  out_word_t       entries_due[$];
  int              errors = 0;
  int              idle_pct = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint absl(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint shifted(input longint c, input longint delta);
    longint m;
    m = c + delta;
    return (absl(m) < longint'(limit_cfg)) ? m : c;
  endfunction

  function automatic bit near_target(input vec3_t p, input vec3_t t);
    longint unsigned sum, d;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d = absl(p[k] - t[k]);
      if (d >= tol_cfg) return 1'b0;
      sum += d * d;
    end
    return sum < tol_cfg * tol_cfg;
  endfunction

  task automatic predict_row(input in_word_t w);
    vec3_t     c, p;
    vec3_t     tgt[6];
    longint    active;
    bit        hit;
    out_word_t e;
    int        n;
    if (w.operation == OP_LOAD) begin
      pts_x[w.cell_index] = w.coord_x;
      pts_y[w.cell_index] = w.coord_y;
      pts_z[w.cell_index] = w.coord_z;
      loaded[w.cell_index] = 1'b1;
      return;
    end
    c[0] = pts_x[w.cell_index];
    c[1] = pts_y[w.cell_index];
    c[2] = pts_z[w.cell_index];
    for (int a = 0; a < 3; a++) begin
      tgt[2*a] = c;
      tgt[2*a+1] = c;
      tgt[2*a][a] = shifted(c[a], -longint'(step_cfg));
      tgt[2*a+1][a] = shifted(c[a], longint'(step_cfg));
    end
    active = cnt_cfg > 64 ? 64 : cnt_cfg;
    n = 0;
    for (int l = 0; l < active; l++) begin
      if (l == w.cell_index) begin
        e.entry_value = ENTRY_DIAG;
      end else begin
        p[0] = pts_x[l];
        p[1] = pts_y[l];
        p[2] = pts_z[l];
        hit = 1'b0;
        for (int a = 0; a < 6; a++) if (near_target(p, tgt[a])) hit = 1'b1;
        if (!hit) continue;
        e.entry_value = ENTRY_NEIGHBOR;
      end
      e.column = l[5:0];
      e.row_last = 1'b0;
      entries_due.push_back(e);
      n++;
    end
    if (n > 0) entries_due[$].row_last = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (entries_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word col %0d", result_o.column));
      end else begin
        if (result_o.column !== entries_due[0].column)
          report_mismatch($sformatf("column %0d, want %0d", result_o.column,
                                    entries_due[0].column));
        if (result_o.entry_value !== entries_due[0].entry_value)
          report_mismatch($sformatf("col %0d value %0d, want %0d", result_o.column,
                                    result_o.entry_value, entries_due[0].entry_value));
        if (result_o.row_last !== entries_due[0].row_last)
          report_mismatch($sformatf("col %0d row_last %0b, want %0b", result_o.column,
                                    result_o.row_last, entries_due[0].row_last));
        void'(entries_due.pop_front());
      end
    end
  end

  task automatic send_word(input in_word_t w);
    in_i <= w;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    predict_row(w);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (entries_due.size() != 0 || busy_o) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_POINT_COUNT: cnt_cfg = val & 32'h7f;
      REG_GRID_STEP:   step_cfg = val & 32'h7fff_ffff;
      REG_POS_LIMIT:   limit_cfg = val & 32'h7fff_ffff;
      default:         tol_cfg = val & 32'h7fff_ffff;
    endcase
  endtask

  task automatic configure(input logic [31:0] cnt, step, lim, tol);
    write_reg(REG_POINT_COUNT, cnt);
    write_reg(REG_GRID_STEP, step);
    write_reg(REG_POS_LIMIT, lim);
    write_reg(REG_MATCH_TOL, tol);
  endtask

  function automatic in_word_t mk(input logic op, input logic [5:0] idx,
                                  input longint x, y, z);
    in_word_t w;
    w.operation = op;
    w.cell_index = idx;
    w.coord_x = x[31:0];
    w.coord_y = y[31:0];
    w.coord_z = z[31:0];
    return w;
  endfunction

  function automatic longint lattice_coord();
    longint k, j, t;
    k = longint'($urandom_range(0, 12)) - 6;
    t = tol_cfg > 1000000 ? 1000000 : longint'(tol_cfg);
    j = longint'($urandom_range(0, 2 * t + 2)) - t - 1;
    if ($urandom_range(9) == 0) return longint'($urandom);
    return k * longint'(step_cfg) + j;
  endfunction

  function automatic bit query_ok(input int idx);
    longint active;
    active = cnt_cfg > 64 ? 64 : cnt_cfg;
    if (!loaded[idx]) return 1'b0;
    for (int l = 0; l < active; l++) if (!loaded[l]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic test_small_rows;
    configure(4, 65536, 655360, 66);
    send_word(mk(OP_LOAD, 0, 0, 0, 0));
    send_word(mk(OP_LOAD, 1, 65536 + 65, 0, 0));
    send_word(mk(OP_LOAD, 2, 0, -65536, 66));
    send_word(mk(OP_LOAD, 3, -2147483648, 2147483647, -2147483648));
    send_word(mk(OP_LOAD, 63, 2147483647, -2147483648, 2147483647));
    for (int i = 0; i < 4; i++) send_word(mk(OP_QUERY, i[5:0], 0, 0, 0));
    send_word(mk(OP_QUERY, 63, -1, -1, -1));
    send_word(mk(OP_LOAD, 2, 0, 0, 0));
    send_word(mk(OP_QUERY, 0, 0, 0, 0));
    send_word(mk(OP_QUERY, 2, 0, 0, 0));
  endtask

  task automatic test_register_extremes;
    drain();
    configure(0, 65536, 655360, 66);
    send_word(mk(OP_QUERY, 0, 0, 0, 0));
    drain();
    configure(4, 0, 655360, 66);
    send_word(mk(OP_QUERY, 0, 0, 0, 0));
    drain();
    configure(4, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(mk(OP_QUERY, 1, 0, 0, 0));
    send_word(mk(OP_QUERY, 3, 0, 0, 0));
    drain();
    configure(4, 65536, 0, 0);
    send_word(mk(OP_QUERY, 2, 0, 0, 0));
    drain();
  endtask

  task automatic test_random_rows(input int n, input int pct,
                                  input logic [31:0] cnt, step, lim, tol);
    in_word_t w;
    int       idx;
    drain();
    configure(cnt, step, lim, tol);
    idle_pct = pct;
    for (int i = 0; i < 64; i++)
      if (!loaded[i]) send_word(mk(OP_LOAD, i[5:0], lattice_coord(), lattice_coord(),
                                   lattice_coord()));
    for (int i = 0; i < n; i++) begin
      idx = $urandom_range(0, 63);
      if ($urandom_range(99) < 55 && query_ok(idx))
        w = mk(OP_QUERY, idx[5:0], longint'($urandom), longint'($urandom),
               longint'($urandom));
      else
        w = mk(OP_LOAD, idx[5:0], lattice_coord(), lattice_coord(), lattice_coord());
      send_word(w);
      if (i == n / 2) drain();
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_rows();
    test_register_extremes();
    test_random_rows(100, 0, 64, 65536, 655360, 66);
    test_random_rows(100, 88, 20, 1000, 5000, 300);
    test_random_rows(100, 37, 127, 32'h7fff_ffff, 32'h7fff_ffff, 2000);
    test_random_rows(80, 0, 64, 300, 32'h7fff_ffff, 200);
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
